>>> design/tfn_pkg.sv
// Shared types and constants for the triangle face normal unit.
package tfn_pkg;

  localparam int unsigned THR_W   = 62;  // threshold register width
  localparam int unsigned SQR_W   = 62;  // one squared, range-reduced component
  localparam int unsigned SQ_W    = 64;  // squared length of the reduced vector
  localparam int unsigned OUT_W   = 32;  // normal component width
  localparam int unsigned D_W     = 31;  // range-reduced component magnitude
  localparam int unsigned QDEPTH  = 4;   // front-to-back queue depth
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  // One classified triangle on its way from the front to the back.
  typedef struct packed {
    logic [2:0][SQR_W-1:0] sqr;
    logic [SQ_W-1:0]       sq;
    logic [2:0]            neg;
    logic                  degen;
  } tfn_item_t;

endpackage

>>> design/tfn_if.sv
// Handshake channel interfaces for triangle items and normal items.
interface tfn_in_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] v0_x;
  logic signed [COORD_WIDTH-1:0] v0_y;
  logic signed [COORD_WIDTH-1:0] v0_z;
  logic signed [COORD_WIDTH-1:0] v1_x;
  logic signed [COORD_WIDTH-1:0] v1_y;
  logic signed [COORD_WIDTH-1:0] v1_z;
  logic signed [COORD_WIDTH-1:0] v2_x;
  logic signed [COORD_WIDTH-1:0] v2_y;
  logic signed [COORD_WIDTH-1:0] v2_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    output ready
  );
endinterface

interface tfn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic               degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

>>> design/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit.
//
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    v0_x..v2_z, signed Q8.16 (COORD_WIDTH bits)
//  out_o     out  valid/ready    normal_x/y/z signed Q1.F (32 bits), degenerate
//  cfg       in   cfg_we_i       cfg_wdata_i: zero_threshold (62 bits)
//
// Throughput is one item per clock while the receiver does not stall. Items
// pass 9 front stages, the queue memory, and 3*NORMAL_FRAC_BITS+3 back stages
// (one quotient bit or one root bit per stage, plus the output register).
// Reset clears all valid bits and the queue, and loads zero_threshold with 1.
// Front and back stall independently; the queue absorbs up to four items.
module triangle_face_normal_unit #(
  parameter int unsigned COORD_WIDTH      = 24,
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tfn_in_if.sink                    in_i,
  tfn_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [tfn_pkg::THR_W-1:0] cfg_wdata_i
);
  import tfn_pkg::*;

  // Degenerate threshold; the user writes it only while the unit is idle, which the block does not enforce.
  logic [THR_W-1:0] thr_q;

  // Front to queue, queue to back.
  tfn_item_t f_item, q_item;
  logic      f_valid, f_ready;
  logic      q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Edges, cross product, range reduction and the degenerate decision.
  tfn_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .thr_i        (thr_q),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  // Decouple the two pipelines so each can stall on its own.
  tfn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (f_item),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .item_o       (q_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  // Normalize: divide each squared component by the squared length, take the root.
  tfn_back #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .out_o        (out_o)
  );

endmodule

>>> design/tfn_front.sv
// Front pipeline: edges, cross product, range reduction, squared length, degenerate test.
module tfn_front #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tfn_in_if.sink                        in_i,
  input  logic [tfn_pkg::THR_W-1:0]     thr_i,
  output tfn_pkg::tfn_item_t            item_o,
  output logic                          item_valid_o,
  input  logic                          item_ready_i
);
  import tfn_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned EW  = CW + 1;
  localparam int unsigned PW  = 2 * EW;
  localparam int unsigned XW  = PW + 1;
  localparam int unsigned MW  = (XW > 32) ? XW : 32;
  localparam int unsigned SW  = $clog2(MW);
  localparam int unsigned NST = 9;

  logic [NST-1:0] vld_q;
  logic           adv;

  logic signed [EW-1:0] e1_d [3];
  logic signed [EW-1:0] e2_d [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [PW-1:0] p_d  [6];
  logic signed [PW-1:0] p_q  [6];
  logic signed [XW-1:0] c_d  [3];
  logic signed [XW-1:0] c_q  [3];
  logic [MW-1:0]        mag4_d [3];
  logic [MW-1:0]        mag4_q [3];
  logic [2:0]           n4_q, n5_q, n6_q, n7_q, n8_q;
  logic [MW-1:0]        or5;
  logic [SW-1:0]        msb5;
  logic [SW-1:0]        s5_d, s5_q;
  logic [MW-1:0]        mag5_q [3];
  logic [D_W-1:0]       d6_q [3];
  logic                 sz6_q, sz7_q, sz8_q;
  logic [SQR_W-1:0]     sqr7_q [3];
  logic [SQR_W-1:0]     sqr8_q [3];
  logic [SQ_W-1:0]      sum8_q;
  tfn_item_t            item_q;

  // Advance the whole front whenever its last stage is empty or drains.
  assign adv          = !vld_q[NST-1] || item_ready_i;
  assign in_i.ready   = adv;
  assign item_valid_o = vld_q[NST-1];
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  always_comb begin
    e1_d[0] = EW'(in_i.v1_x) - EW'(in_i.v0_x);
    e1_d[1] = EW'(in_i.v1_y) - EW'(in_i.v0_y);
    e1_d[2] = EW'(in_i.v1_z) - EW'(in_i.v0_z);
    e2_d[0] = EW'(in_i.v2_x) - EW'(in_i.v1_x);
    e2_d[1] = EW'(in_i.v2_y) - EW'(in_i.v1_y);
    e2_d[2] = EW'(in_i.v2_z) - EW'(in_i.v1_z);
  end

  always_comb begin
    p_d[0] = e1_q[1] * e2_q[2];
    p_d[1] = e1_q[2] * e2_q[1];
    p_d[2] = e1_q[2] * e2_q[0];
    p_d[3] = e1_q[0] * e2_q[2];
    p_d[4] = e1_q[0] * e2_q[1];
    p_d[5] = e1_q[1] * e2_q[0];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_d[k]    = XW'(p_q[2*k]) - XW'(p_q[2*k+1]);
      mag4_d[k] = MW'(c_q[k][XW-1] ? -c_q[k] : c_q[k]);
    end
  end

  // Least right shift that brings the largest magnitude below 2^31.
  always_comb begin
    or5  = mag4_q[0] | mag4_q[1] | mag4_q[2];
    msb5 = '0;
    for (int i = 0; i < MW; i++) begin
      if (or5[i]) begin
        msb5 = SW'(i);
      end
    end
    s5_d = (or5[MW-1:31] != '0) ? msb5 - SW'(30) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
      p_q  <= p_d;
      c_q  <= c_d;
      mag4_q <= mag4_d;
      n4_q <= {c_q[2][XW-1], c_q[1][XW-1], c_q[0][XW-1]};
      s5_q   <= s5_d;
      mag5_q <= mag4_q;
      n5_q   <= n4_q;
      for (int k = 0; k < 3; k++) begin
        d6_q[k]   <= D_W'(mag5_q[k] >> s5_q);
        sqr7_q[k] <= SQR_W'(d6_q[k] * d6_q[k]);
      end
      sz6_q  <= (s5_q == '0);
      n6_q   <= n5_q;
      sz7_q  <= sz6_q;
      n7_q   <= n6_q;
      sum8_q <= SQ_W'(sqr7_q[0]) + SQ_W'(sqr7_q[1]) + SQ_W'(sqr7_q[2]);
      sqr8_q <= sqr7_q;
      sz8_q  <= sz7_q;
      n8_q   <= n7_q;
      item_q.sqr   <= {sqr8_q[2], sqr8_q[1], sqr8_q[0]};
      item_q.sq    <= sum8_q;
      item_q.neg   <= n8_q;
      item_q.degen <= (sum8_q == '0) || (sz8_q && (sum8_q < SQ_W'(thr_i)));
    end
  end

endmodule

>>> design/tfn_queue.sv
// Short item queue between the front and back pipelines.
module tfn_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfn_pkg::tfn_item_t item_i,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  output tfn_pkg::tfn_item_t item_o,
  output logic               pop_valid_o,
  input  logic               pop_ready_i
);
  import tfn_pkg::*;

  tfn_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((wr_q - rd_q) == QPTR_W'(cnt_q)))
    else $error("queue pointers disagree with fill count");

endmodule

>>> design/tfn_back.sv
// Back pipeline: per-component restoring division and square root, then output register.
module tfn_back #(
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfn_pkg::tfn_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  tfn_out_if.source          out_o
);
  import tfn_pkg::*;

  localparam int unsigned F  = NORMAL_FRAC_BITS;
  localparam int unsigned QW = 2 * F + 1;
  localparam int unsigned ND = QW;
  localparam int unsigned NS = F + 1;
  localparam int unsigned NT = ND + NS;
  localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << F;

  logic [NT-1:0]   vld_q;
  logic [2:0]      neg_q [NT];
  logic            dg_q  [NT];
  logic [SQ_W-1:0] r_q   [ND][3];
  logic [QW-1:0]   q_q   [ND][3];
  logic [SQ_W-1:0] sq_q  [ND];
  logic [QW-1:0]   sv_q  [NS][3];
  logic [QW-1:0]   sr_q  [NS][3];
  logic            adv, take, vo_q;
  logic signed [OUT_W-1:0] nx_q, ny_q, nz_q;
  logic            dgo_q;

  // Hold every stage while the output register is full and not taken.
  assign adv          = !vo_q || out_o.ready;
  assign take         = item_valid_i && adv;
  assign item_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vo_q  <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[NT-2:0], take};
      vo_q  <= vld_q[NT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q[0] <= item_i.neg;
      dg_q[0]  <= item_i.degen;
      for (int i = 1; i < NT; i++) begin
        neg_q[i] <= neg_q[i-1];
        dg_q[i]  <= dg_q[i-1];
      end
    end
  end

  // One quotient bit per stage; the first stage settles the integer bit.
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [SQ_W-1:0] r_in [3];
    logic [QW-1:0]   q_in [3];
    logic [SQ_W-1:0] s_in;
    logic [SQ_W:0]   t    [3];
    logic [SQ_W-1:0] r_nx [3];
    logic [2:0]      b;

    if (k == 0) begin : g_head
      always_comb begin
        s_in = item_i.sq;
        for (int l = 0; l < 3; l++) begin
          r_in[l] = SQ_W'(item_i.sqr[l]);
          q_in[l] = '0;
        end
      end
    end else begin : g_tail
      always_comb begin
        s_in = sq_q[k-1];
        for (int l = 0; l < 3; l++) begin
          r_in[l] = r_q[k-1][l];
          q_in[l] = q_q[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]    = (k == 0) ? {1'b0, r_in[l]} : {r_in[l], 1'b0};
        b[l]    = (t[l] >= {1'b0, s_in});
        r_nx[l] = b[l] ? SQ_W'(t[l] - {1'b0, s_in}) : SQ_W'(t[l]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k] <= s_in;
        for (int l = 0; l < 3; l++) begin
          r_q[k][l] <= r_nx[l];
          q_q[k][l] <= {q_in[l][QW-2:0], b[l]};
        end
      end
    end
  end

  // One root bit per stage.
  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam logic [QW-1:0] BITV = QW'(1) << (2 * (F - j));
    logic [QW-1:0] v_in [3];
    logic [QW-1:0] res_in [3];
    logic [2:0]    ge;

    if (j == 0) begin : g_head
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          v_in[l]   = q_q[ND-1][l];
          res_in[l] = '0;
        end
      end
    end else begin : g_tail
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          v_in[l]   = sv_q[j-1][l];
          res_in[l] = sr_q[j-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = ({1'b0, v_in[l]} >= ({1'b0, res_in[l]} + {1'b0, BITV}));
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          sv_q[j][l] <= ge[l] ? v_in[l] - res_in[l] - BITV : v_in[l];
          sr_q[j][l] <= ge[l] ? (res_in[l] >> 1) + BITV : (res_in[l] >> 1);
        end
      end
    end
  end

  function automatic logic signed [OUT_W-1:0] apply_sign(input logic [F:0] mag,
                                                          input logic neg);
    logic [OUT_W-1:0] m;
    m = OUT_W'(mag);
    return neg ? -m : m;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dgo_q <= dg_q[NT-1];
      if (dg_q[NT-1]) begin
        nx_q <= ONE;
        ny_q <= '0;
        nz_q <= '0;
      end else begin
        nx_q <= apply_sign(sr_q[NS-1][0][F:0], neg_q[NT-1][0]);
        ny_q <= apply_sign(sr_q[NS-1][1][F:0], neg_q[NT-1][1]);
        nz_q <= apply_sign(sr_q[NS-1][2][F:0], neg_q[NT-1][2]);
      end
    end
  end

  assign out_o.valid      = vo_q;
  assign out_o.normal_x   = nx_q;
  assign out_o.normal_y   = ny_q;
  assign out_o.normal_z   = nz_q;
  assign out_o.degenerate = dgo_q;

  a_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && dgo_q) |-> (nx_q == ONE && ny_q == '0 && nz_q == '0))
    else $error("degenerate item without fallback normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !dgo_q) |-> (nx_q <= ONE && nx_q >= -ONE && ny_q <= ONE && ny_q >= -ONE
                          && nz_q <= ONE && nz_q >= -ONE))
    else $error("normal component beyond unit range");

endmodule

>>> test/triangle_face_normal_unit_tb.sv
// Self-checking testbench for the triangle face normal unit.
`timescale 1ns / 100ps

module triangle_face_normal_unit_tb;
  import tfn_pkg::*;

  localparam int          NF        = 30;
  localparam int          CW        = 24;
  localparam int          K         = 65536;          // 1.0 in Q8.16
  localparam int          CMIN      = -8388608;
  localparam int          CMAX      = 8388607;
  localparam int          ONE       = 1 << NF;        // 1.0 in Q1.30
  localparam int          N_DIR     = 13;
  localparam int          N_PHASE   = 6;
  localparam int          PER_PHASE = 66;
  localparam int          DRAIN     = 120;            // longer than the unit's latency
  localparam int unsigned LIMIT     = 200000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t c [9];
  } tri_t;
  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic               degen;
  } normal_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [THR_W-1:0]  cfg_wdata_i = '0;
  logic [THR_W-1:0]  zero_thr = 62'd1;  // mirrors the register
  normal_t           normal_fifo [$];
  int                mismatches = 0;
  int unsigned       cycles = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;

  tfn_in_if #(.COORD_WIDTH(CW)) in_bus ();
  tfn_out_if                    out_bus ();

  triangle_face_normal_unit #(
    .COORD_WIDTH      (CW),
    .NORMAL_FRAC_BITS (NF)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Directed triangles: vertex coordinates, then the normal where it is obvious.
  int dir_coord [N_DIR][9] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, K, 0, 0, K, K, 0},
    '{0, 0, 0, K, 0, 0, K, -K, 0},
    '{0, 0, 0, 0, K, 0, 0, K, K},
    '{0, 0, 0, 0, 0, K, K, 0, K},
    '{0, 0, 0, 1, 0, 0, 1, 1, 0},
    '{0, 0, 0, K, K, K, 2*K, 2*K, 2*K},
    '{5, 6, 7, 5, 6, 7, 100, 200, 300},
    '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN},
    '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0},
    '{CMIN, CMAX, 0, CMAX, CMIN, CMAX, 0, CMIN, CMAX},
    '{0, 0, 0, K, 0, 0, 0, K, K},
    '{5592405, -5592406, 5592405, -5592406, 5592405, -5592406, 1, -1, 0}
  };
  bit dir_known [N_DIR] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0};
  int dir_exp [N_DIR][4] = '{
    '{ONE, 0, 0, 1}, '{0, 0, ONE, 0}, '{0, 0, -ONE, 0}, '{ONE, 0, 0, 0},
    '{0, ONE, 0, 0}, '{0, 0, ONE, 0}, '{ONE, 0, 0, 1}, '{ONE, 0, 0, 1},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}
  };

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Exact cross product, range reduction below 2^31, then per-axis
  // floor(sqrt(d^2 * 2^60 / S)) with the sign of the cross product.
  function automatic normal_t face_normal(tri_t t, logic [THR_W-1:0] thr);
    longint          e1 [3];
    longint          e2 [3];
    longint          cr [3];
    longint unsigned mag [3];
    longint unsigned mx;
    longint unsigned sq;
    logic [127:0]    quo;
    longint unsigned root;
    int              s;
    normal_t         r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t.c[3+i]) - longint'(t.c[i]);
      e2[i] = longint'(t.c[6+i]) - longint'(t.c[3+i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
      if (mag[i] > mx) mx = mag[i];
    end
    s = 0;
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      s++;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      sq     = sq + mag[i] * mag[i];
    end
    if (sq == 0 || (s == 0 && sq < 64'(thr))) begin
      r.nx = ONE; r.ny = 0; r.nz = 0; r.degen = 1'b1;
      return r;
    end
    r.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      quo  = ({64'd0, mag[i] * mag[i]} << (2 * NF)) / {64'd0, sq};
      root = int_sqrt(quo[63:0]);
      case (i)
        0: r.nx = (cr[i] < 0) ? -32'(root) : 32'(root);
        1: r.ny = (cr[i] < 0) ? -32'(root) : 32'(root);
        default: r.nz = (cr[i] < 0) ? -32'(root) : 32'(root);
      endcase
    end
    return r;
  endfunction

  function automatic coord_t small_coord();
    return coord_t'($signed($urandom_range(0, 511)) - 256);
  endfunction

  // Random triangle: mostly full range, plus small, collinear, shared-vertex
  // and near-degenerate shapes that exercise the threshold.
  function automatic tri_t random_tri();
    tri_t t;
    int   kind;
    int   step [3];
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) t.c[i] = coord_t'($urandom);
    case (kind)
      4, 5: begin
        for (int i = 0; i < 9; i++) t.c[i] = small_coord();
      end
      6: begin
        for (int i = 0; i < 3; i++) begin
          step[i]  = $signed($urandom_range(0, 4095)) - 2048;
          t.c[i]   = coord_t'($signed($urandom_range(0, 2000000)) - 1000000);
          t.c[3+i] = t.c[i] + coord_t'(step[i]);
          t.c[6+i] = t.c[3+i] + coord_t'(step[i] * $urandom_range(0, 3));
        end
      end
      7: begin
        for (int i = 0; i < 3; i++) t.c[3+i] = t.c[$urandom_range(0, 1) ? i : 6+i];
      end
      8: begin
        for (int i = 0; i < 3; i++) begin
          t.c[3+i] = t.c[i] + small_coord();
          t.c[6+i] = t.c[3+i] + small_coord();
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  // Offer one triangle, idle at random first; record its normal on acceptance.
  task automatic offer_tri(tri_t t, bit known, normal_t want);
    normal_t exp_n;
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.v0_x = t.c[0]; in_bus.v0_y = t.c[1]; in_bus.v0_z = t.c[2];
    in_bus.v1_x = t.c[3]; in_bus.v1_y = t.c[4]; in_bus.v1_z = t.c[5];
    in_bus.v2_x = t.c[6]; in_bus.v2_y = t.c[7]; in_bus.v2_z = t.c[8];
    do @(posedge clk_i); while (!in_bus.ready);
    if (known) begin
      exp_n = want;
    end else begin
      exp_n = face_normal(t, zero_thr);
    end
    normal_fifo.insert(normal_fifo.size(), exp_n);
    @(negedge clk_i);
  endtask

  task automatic drain_normals();
    in_bus.valid = 1'b0;
    while (normal_fifo.size() != 0) @(negedge clk_i);
  endtask

  // Write the threshold only once the pipe is empty.
  task automatic set_threshold(logic [THR_W-1:0] thr);
    drain_normals();
    repeat (DRAIN) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = thr;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    zero_thr = thr;
  endtask

  // Receiver: stall at random on the falling edge.
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(1, 100) > recv_idle_pct);
  end

  // Compare each accepted normal with the oldest prediction.
  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (normal_fifo.size() == 0) begin
        $error("unexpected normal item: %0d %0d %0d deg %0b", out_bus.normal_x,
               out_bus.normal_y, out_bus.normal_z, out_bus.degenerate);
        mismatches++;
      end else begin
        want = normal_fifo.pop_front();
        if (out_bus.normal_x !== want.nx) begin
          $error("normal_x: expected %0d, got %0d", want.nx, out_bus.normal_x);
          mismatches++;
        end
        if (out_bus.normal_y !== want.ny) begin
          $error("normal_y: expected %0d, got %0d", want.ny, out_bus.normal_y);
          mismatches++;
        end
        if (out_bus.normal_z !== want.nz) begin
          $error("normal_z: expected %0d, got %0d", want.nz, out_bus.normal_z);
          mismatches++;
        end
        if (out_bus.degenerate !== want.degen) begin
          $error("degenerate: expected %0b, got %0b", want.degen, out_bus.degenerate);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("triangle_face_normal_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    tri_t             t;
    normal_t          want;
    logic [THR_W-1:0] phase_thr [N_PHASE];
    in_bus.valid  = 1'b0;
    in_bus.v0_x = '0; in_bus.v0_y = '0; in_bus.v0_z = '0;
    in_bus.v1_x = '0; in_bus.v1_y = '0; in_bus.v1_z = '0;
    in_bus.v2_x = '0; in_bus.v2_y = '0; in_bus.v2_z = '0;
    phase_thr = '{62'd0, {62{1'b1}}, 62'd1 << 20,
                  THR_W'({$urandom, $urandom}), 62'd1 << 40, 62'd1};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset threshold of 1, with mild idling.
    send_idle_pct = 33;
    recv_idle_pct = 69;
    for (int r = 0; r < N_DIR; r++) begin
      for (int i = 0; i < 9; i++) t.c[i] = coord_t'(dir_coord[r][i]);
      want.nx = dir_exp[r][0];
      want.ny = dir_exp[r][1];
      want.nz = dir_exp[r][2];
      want.degen = dir_exp[r][3][0];
      offer_tri(t, dir_known[r], want);
    end

    // Random phases: swap idling roles, then run without idling.
    for (int p = 0; p < N_PHASE; p++) begin
      set_threshold(phase_thr[p]);
      send_idle_pct = (p < 2) ? 33 : (p < 4) ? 69 : 0;
      recv_idle_pct = (p < 2) ? 69 : (p < 4) ? 33 : 0;
      for (int n = 0; n < PER_PHASE; n++) begin
        // Hold off once until the pipe has fully emptied.
        if (p == 1 && n == PER_PHASE / 2) drain_normals();
        offer_tri(random_tri(), 1'b0, want);
      end
    end

    drain_normals();
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("triangle_face_normal_unit_tb: clean");
    end else begin
      $display("triangle_face_normal_unit_tb: errors");
    end
    $finish;
  end

endmodule
